### rtl/core/walt_pkg.sv
// Shared types, codes and constants of the write-ahead log tracker.
// Used by walt_ctrl, walt_dp and write_ahead_log_tracker_core; no dependencies.
`default_nettype none

package walt_pkg;

  localparam int LOG_ENTRIES_DEF = 32;
  // Log block addresses wrap at this many bits before they reach the port.
  localparam int BLOCK_ADDR_BITS = 32;

  localparam int BLK_W     = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 4;
  localparam int REGION_W  = 6;
  localparam int RESERVE_W = 6;
  localparam int OPS_W     = 6;
  localparam int NEED_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int HSEL_W    = 2;

  localparam logic [BLK_W-1:0] LOG_BLOCK_MASK =
      (BLOCK_ADDR_BITS >= BLK_W) ? {BLK_W{1'b1}} :
      ((BLK_W'(1) << BLOCK_ADDR_BITS) - BLK_W'(1));

  localparam logic [OPS_W-1:0] OPS_MAX = {OPS_W{1'b1}};

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ABSORBED = 4'd2;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 4'd3;
  localparam logic [STATUS_W-1:0] ST_COMMIT   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ENDED    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FULL     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_MISUSE   = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE    = 2'd2;

  localparam logic [BLK_W-1:0]     LOG_START_RST = 32'd2;
  localparam logic [REGION_W-1:0]  REGION_RST    = 6'd31;
  localparam logic [RESERVE_W-1:0] RESERVE_RST   = 6'd10;

  // Source of the home_block field of a result.
  localparam logic [HSEL_W-1:0] HSEL_ZERO  = 2'd0;
  localparam logic [HSEL_W-1:0] HSEL_REQ   = 2'd1;
  localparam logic [HSEL_W-1:0] HSEL_TABLE = 2'd2;

  typedef struct packed {
    logic                latch;
    logic                open_inc;
    logic                open_dec;
    logic                idx_clear;
    logic                idx_inc;
    logic                append;
    logic                clear_count;
    logic                emit;
    logic [STATUS_W-1:0] code;
    logic [HSEL_W-1:0]   home_sel;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             begin_ok;
    logic             full;
    logic             open_zero;
    logic             open_one;
    logic             count_zero;
    logic             match;
    logic             idx_last;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/walt_ctrl.sv
// Controller state machine of the write-ahead log tracker.
// Depends on walt_pkg for the command and status structs and the codes.
`default_nettype none

module walt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire walt_pkg::sts_t  sts,
  output walt_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SRD    = 3'd2;
  localparam logic [2:0] S_SCMP   = 3'd3;
  localparam logic [2:0] S_CRD    = 3'd4;
  localparam logic [2:0] S_CEMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          cmd.last   = 1'b1;
          cmd.emit   = 1'b1;
          case (sts.req)
            walt_pkg::REQ_BEGIN: begin
              cmd.open_inc = sts.begin_ok;
              cmd.code     = sts.begin_ok ? walt_pkg::ST_GRANTED : walt_pkg::ST_WAIT;
            end
            walt_pkg::REQ_WRITE: begin
              cmd.home_sel = walt_pkg::HSEL_REQ;
              if (sts.full) begin
                cmd.code = walt_pkg::ST_FULL;
              end else if (sts.open_zero) begin
                cmd.code = walt_pkg::ST_MISUSE;
              end else if (sts.count_zero) begin
                cmd.append = 1'b1;
                cmd.code   = walt_pkg::ST_APPENDED;
              end else begin
                cmd.emit      = 1'b0;
                cmd.idx_clear = 1'b1;
                state_next    = S_SRD;
              end
            end
            walt_pkg::REQ_END: begin
              if (sts.open_zero) begin
                cmd.code = walt_pkg::ST_MISUSE;
              end else begin
                cmd.open_dec = 1'b1;
                if (!sts.open_one) begin
                  cmd.code = walt_pkg::ST_ENDED;
                end else if (sts.count_zero) begin
                  cmd.code = walt_pkg::ST_EMPTY;
                end else begin
                  // Last operation closed with blocks logged: run the commit.
                  cmd.emit      = 1'b0;
                  cmd.idx_clear = 1'b1;
                  state_next    = S_CRD;
                end
              end
            end
            default: begin
              cmd.code = walt_pkg::ST_MISUSE;
            end
          endcase
        end
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (sts.out_free) begin
          cmd.home_sel = walt_pkg::HSEL_REQ;
          cmd.last     = 1'b1;
          if (sts.match) begin
            cmd.emit   = 1'b1;
            cmd.code   = walt_pkg::ST_ABSORBED;
            state_next = S_IDLE;
          end else if (sts.idx_last) begin
            cmd.emit   = 1'b1;
            cmd.append = 1'b1;
            cmd.code   = walt_pkg::ST_APPENDED;
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SRD;
          end
        end
      end
      S_CRD: begin
        state_next = S_CEMIT;
      end
      S_CEMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.code     = walt_pkg::ST_COMMIT;
          cmd.home_sel = walt_pkg::HSEL_TABLE;
          cmd.last     = sts.idx_last;
          if (sts.idx_last) begin
            cmd.clear_count = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_CRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/walt_dp.sv
// Datapath of the write-ahead log tracker: configuration, counters, the
// home block table memory and the output register. Depends on walt_pkg.
`default_nettype none

module walt_dp #(
  parameter int LOG_ENTRIES = walt_pkg::LOG_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [walt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [walt_pkg::BLK_W-1:0]     cfg_wdata,
  input  wire logic [walt_pkg::REQ_W-1:0]     in_req,
  input  wire logic [walt_pkg::BLK_W-1:0]     in_block,
  input  wire walt_pkg::cmd_t                 cmd,
  output walt_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [walt_pkg::STATUS_W-1:0]       out_status,
  output logic [walt_pkg::BLK_W-1:0]          out_log_block,
  output logic [walt_pkg::BLK_W-1:0]          out_home_block,
  output logic                                out_last
);

  localparam int CNT_W = $clog2(LOG_ENTRIES + 1);
  localparam int IDX_W = $clog2(LOG_ENTRIES);
  localparam int CMP_W = 8;

  logic [walt_pkg::BLK_W-1:0]     log_start;
  logic [walt_pkg::REGION_W-1:0]  region_blocks;
  logic [walt_pkg::RESERVE_W-1:0] reserve;

  logic [CNT_W-1:0]           entry_count;
  logic [walt_pkg::OPS_W-1:0] open_ops;
  logic [IDX_W-1:0]           idx;
  logic [walt_pkg::REQ_W-1:0] req;
  logic [walt_pkg::BLK_W-1:0] blk;

  logic [walt_pkg::BLK_W-1:0] home_mem [LOG_ENTRIES];
  logic [walt_pkg::BLK_W-1:0] rd_data;

  logic [walt_pkg::OPS_W:0]      ops_plus;
  logic [walt_pkg::NEED_W-1:0]   need;
  logic [walt_pkg::REGION_W-1:0] region_cap;
  logic [walt_pkg::BLK_W:0]      log_sum;
  logic [walt_pkg::BLK_W-1:0]    home_sel_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start     <= walt_pkg::LOG_START_RST;
      region_blocks <= walt_pkg::REGION_RST;
      reserve       <= walt_pkg::RESERVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        walt_pkg::REG_LOG_START: log_start     <= cfg_wdata;
        walt_pkg::REG_REGION:    region_blocks <= cfg_wdata[walt_pkg::REGION_W-1:0];
        walt_pkg::REG_RESERVE:   reserve       <= cfg_wdata[walt_pkg::RESERVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      open_ops    <= '0;
    end else begin
      if (cmd.clear_count) begin
        entry_count <= '0;
      end else if (cmd.append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (cmd.open_inc) begin
        open_ops <= open_ops + walt_pkg::OPS_W'(1);
      end else if (cmd.open_dec) begin
        open_ops <= open_ops - walt_pkg::OPS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= in_req;
      blk <= in_block;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Table with a write port and a registered read port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      home_mem[entry_count[IDX_W-1:0]] <= blk;
    end
    rd_data <= home_mem[idx];
  end

  always_comb begin
    ops_plus   = (walt_pkg::OPS_W + 1)'(open_ops) + (walt_pkg::OPS_W + 1)'(1);
    need       = walt_pkg::NEED_W'(entry_count)
               + walt_pkg::NEED_W'(ops_plus) * walt_pkg::NEED_W'(reserve);
    region_cap = (region_blocks == '0) ? '0 : region_blocks - walt_pkg::REGION_W'(1);
    log_sum    = (walt_pkg::BLK_W + 1)'(log_start) + (walt_pkg::BLK_W + 1)'(idx)
               + (walt_pkg::BLK_W + 1)'(1);

    sts.req        = req;
    sts.begin_ok   = (open_ops != walt_pkg::OPS_MAX)
                   && (need <= walt_pkg::NEED_W'(LOG_ENTRIES));
    sts.full       = (CMP_W'(entry_count) >= CMP_W'(region_cap))
                   || (entry_count >= CNT_W'(LOG_ENTRIES));
    sts.open_zero  = (open_ops == '0);
    sts.open_one   = (open_ops == walt_pkg::OPS_W'(1));
    sts.count_zero = (entry_count == '0);
    sts.match      = (rd_data == blk);
    sts.idx_last   = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
    sts.out_free   = !out_valid || out_ready;

    case (cmd.home_sel)
      walt_pkg::HSEL_REQ:   home_sel_val = blk;
      walt_pkg::HSEL_TABLE: home_sel_val = rd_data;
      default:              home_sel_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status     <= cmd.code;
      out_home_block <= home_sel_val;
      out_last       <= cmd.last;
      out_log_block  <= (cmd.code == walt_pkg::ST_COMMIT)
                      ? (log_sum[walt_pkg::BLK_W-1:0] & walt_pkg::LOG_BLOCK_MASK) : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(LOG_ENTRIES))
    else $error("entry count beyond table depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a word still waiting");

  a_append_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (!sts.full && !sts.open_zero))
    else $error("append into a full log or outside an operation");

  a_dec_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.open_dec |-> !sts.open_zero)
    else $error("open operation count would wrap below zero");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("append did not advance the entry count");

endmodule

`default_nettype wire

### rtl/core/write_ahead_log_tracker_core.sv
// Write-ahead log tracker with group commit. A request is taken on the
// slave stream only while no earlier request is in progress. Begin and end
// requests that do not commit, and writes that hit a full log, an empty table
// or no open operation, are settled in DECIDE. A write that searches the
// table reads and compares one slot at a time (SRD, then SCMP) until a match,
// or through all slots when the block is appended. A commit reads and emits
// the logged blocks one slot at a time (CRD, then CEMIT); the registered table
// read sets the read state per slot. Result words wait in one output register,
// so a stalled master side holds the block only when a further result is due.
// The table is not cleared after reset; only written slots are ever read.
// Depends on walt_pkg, walt_ctrl and walt_dp.
`default_nettype none

module write_ahead_log_tracker_core #(
  parameter int LOG_ENTRIES = walt_pkg::LOG_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [walt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [walt_pkg::BLK_W-1:0]     cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [31:0]                    s_tdata,  // block_number
  input  wire logic [1:0]                     s_tuser,  // req_type
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [63:0]                         m_tdata,  // log_block, home_block
  output logic [3:0]                          m_tuser,  // status
  output logic                                m_tlast
);

  walt_pkg::cmd_t cmd;
  walt_pkg::sts_t sts;

  logic [walt_pkg::BLK_W-1:0] log_block;
  logic [walt_pkg::BLK_W-1:0] home_block;

  walt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  walt_dp #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req         (s_tuser),
    .in_block       (s_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (m_tuser),
    .out_log_block  (log_block),
    .out_home_block (home_block),
    .out_last       (m_tlast)
  );

  assign m_tdata = {home_block, log_block};

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for write_ahead_log_tracker_core: sends begin, write, end and unused-code requests
// with random pacing on both streams, predicts every result word and checks them in order.
// Depends on walt_pkg and the tracker RTL.

module tb_top;
  import walt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 40;

  // The request code that the block has no meaning for.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    log_blk;
    logic [BLK_W-1:0]    home_blk;
    logic                last;
  } wal_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLK_W-1:0]     cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;   // block_number
  logic [1:0]           s_tuser;   // req_type
  logic                 m_tvalid;
  logic                 m_tready;
  logic [63:0]          m_tdata;   // log_block, home_block
  logic [3:0]           m_tuser;   // status
  logic                 m_tlast;

  write_ahead_log_tracker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Shadow copy of the tracker: configuration, open operations and the logged blocks.
  logic [BLK_W-1:0]     log_start_q;
  logic [REGION_W-1:0]  region_q;
  logic [RESERVE_W-1:0] reserve_q;
  int                   entry_cnt;
  int                   open_cnt;
  logic [BLK_W-1:0]     home_tbl [LOG_ENTRIES_DEF];
  wal_result_t          due_results [$];
  wal_result_t          head;

  int  tx_idle_pct;
  int  rx_stall_pct;
  bit  rx_hold;
  int  cycles;
  int  items_sent;
  int  words_checked;
  int  mismatch_count;
  int  commits_due;
  int  waits_due;
  int  absorbs_due;
  int  fulls_due;
  event rx_hold_ev;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_LOG_START;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_BEGIN;
    m_tready = 1'b0;
    rx_hold = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    cycles = 0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               due_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [BLK_W-1:0] got,
                                 input logic [BLK_W-1:0] want);
    if (mismatch_count < REPORT_MAX) begin
      $display("%0t ns: word %0d %s: got %h, want %h", $time, words_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_checked++;
      if (due_results.size() == 0) begin
        report_mismatch("arrived with nothing expected, status", BLK_W'(m_tuser), '0);
      end else begin
        head = due_results.pop_front();
        if (m_tuser != head.status) report_mismatch("status", BLK_W'(m_tuser), BLK_W'(head.status));
        if (m_tdata[31:0] != head.log_blk) report_mismatch("log_block", m_tdata[31:0], head.log_blk);
        if (m_tdata[63:32] != head.home_blk) begin
          report_mismatch("home_block", m_tdata[63:32], head.home_blk);
        end
        if (m_tlast != head.last) report_mismatch("last", BLK_W'(m_tlast), BLK_W'(head.last));
      end
    end
  end

  function automatic int log_capacity();
    int cap;
    cap = (region_q > 0) ? int'(region_q) - 1 : 0;
    if (cap > LOG_ENTRIES_DEF) cap = LOG_ENTRIES_DEF;
    return cap;
  endfunction

  task automatic push_result(input logic [STATUS_W-1:0] status, input logic [BLK_W-1:0] lb,
                             input logic [BLK_W-1:0] hb, input logic last);
    wal_result_t r;
    r.status = status;
    r.log_blk = lb;
    r.home_blk = hb;
    r.last = last;
    due_results.push_back(r);
  endtask

  // Works out the result words of one accepted request and updates the shadow state.
  task automatic track_request(input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk);
    int need;
    bit hit;
    case (req)
      REQ_BEGIN: begin
        need = entry_cnt + (open_cnt + 1) * int'(reserve_q);
        if (open_cnt >= int'(OPS_MAX) || need > LOG_ENTRIES_DEF) begin
          push_result(ST_WAIT, '0, '0, 1'b1);
          waits_due++;
        end else begin
          open_cnt++;
          push_result(ST_GRANTED, '0, '0, 1'b1);
        end
      end
      REQ_WRITE: begin
        // A full log wins even when the block is already logged.
        if (entry_cnt >= log_capacity()) begin
          push_result(ST_FULL, '0, blk, 1'b1);
          fulls_due++;
        end else if (open_cnt == 0) begin
          push_result(ST_MISUSE, '0, blk, 1'b1);
        end else begin
          hit = 1'b0;
          for (int i = 0; i < entry_cnt; i++) begin
            if (home_tbl[i] == blk) hit = 1'b1;
          end
          if (hit) begin
            push_result(ST_ABSORBED, '0, blk, 1'b1);
            absorbs_due++;
          end else begin
            home_tbl[entry_cnt] = blk;
            entry_cnt++;
            push_result(ST_APPENDED, '0, blk, 1'b1);
          end
        end
      end
      REQ_END: begin
        if (open_cnt == 0) begin
          push_result(ST_MISUSE, '0, '0, 1'b1);
        end else begin
          open_cnt--;
          if (open_cnt != 0) begin
            push_result(ST_ENDED, '0, '0, 1'b1);
          end else if (entry_cnt == 0) begin
            push_result(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < entry_cnt; i++) begin
              push_result(ST_COMMIT, (log_start_q + BLK_W'(i + 1)) & LOG_BLOCK_MASK,
                          home_tbl[i], i == entry_cnt - 1);
            end
            commits_due += entry_cnt;
            entry_cnt = 0;
          end
        end
      end
      default: begin
        push_result(ST_MISUSE, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= blk;
    do @(posedge clk); while (!s_tready);
    track_request(req, blk);
    items_sent++;
  endtask

  // Drops the request stream and waits until every expected word has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [BLK_W-1:0] start, input int region, input int reserve);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOG_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= REG_REGION;
    cfg_wdata <= BLK_W'(region);
    @(posedge clk);
    cfg_index <= REG_RESERVE;
    cfg_wdata <= BLK_W'(reserve);
    @(posedge clk);
    cfg_we <= 1'b0;
    log_start_q = start;
    region_q = REGION_W'(region);
    reserve_q = RESERVE_W'(reserve);
  endtask

  // Often a block already in the log, so that absorption gets exercised.
  function automatic logic [BLK_W-1:0] pick_block();
    int r;
    r = $urandom_range(99);
    if (r < 40 && entry_cnt > 0) return home_tbl[$urandom_range(entry_cnt - 1)];
    if (r < 60) return BLK_W'($urandom_range(15));
    if (r < 65) return '1;
    return $urandom;
  endfunction

  task automatic test_misuse_cases();
    send_req(REQ_END, $urandom);
    send_req(REQ_WRITE, 32'hFFFF_FFFF);
    send_req(REQ_UNUSED, $urandom);
    send_req(REQ_BEGIN, $urandom);
    send_req(REQ_END, $urandom);
    settle();
  endtask

  task automatic test_group_commit();
    send_req(REQ_BEGIN, '0);
    send_req(REQ_WRITE, '0);
    send_req(REQ_WRITE, 32'hFFFF_FFFF);
    send_req(REQ_WRITE, '0);
    send_req(REQ_BEGIN, '1);
    send_req(REQ_END, '1);
    send_req(REQ_END, '0);
    settle();
  endtask

  // Two-slot log, and log block addresses that wrap past the top of the address space.
  task automatic test_full_log_wrap();
    write_regs(32'hFFFF_FFFF, 3, 1);
    send_req(REQ_BEGIN, $urandom);
    send_req(REQ_WRITE, 32'd5);
    send_req(REQ_WRITE, 32'd9);
    send_req(REQ_WRITE, 32'd5);
    send_req(REQ_WRITE, 32'd7);
    send_req(REQ_END, $urandom);
    settle();
  endtask

  task automatic test_admission_limits();
    // No log capacity at all, and a reserve of 32.
    write_regs('0, 0, 32);
    send_req(REQ_BEGIN, $urandom);
    send_req(REQ_BEGIN, $urandom);
    send_req(REQ_WRITE, $urandom);
    send_req(REQ_END, $urandom);
    settle();
    // A zero reserve admits begins until the open count saturates.
    write_regs(32'h1234_5678, 2, 0);
    repeat (int'(OPS_MAX) + 1) send_req(REQ_BEGIN, $urandom);
    send_req(REQ_WRITE, 32'h0000_0001);
    send_req(REQ_WRITE, 32'h8000_0000);
    repeat (int'(OPS_MAX)) send_req(REQ_END, $urandom);
    settle();
  endtask

  // Fill every slot while the receiver is held off, then commit the whole log.
  task automatic test_backpressure_fill();
    logic [BLK_W-1:0] base;
    base = $urandom;
    write_regs($urandom, 33, 1);
    -> rx_hold_ev;
    send_req(REQ_BEGIN, $urandom);
    for (int i = 0; i < LOG_ENTRIES_DEF + 2; i++) send_req(REQ_WRITE, base + BLK_W'(i));
    send_req(REQ_END, $urandom);
    settle();
  endtask

  task automatic random_traffic(input int n_items);
    int start_cnt;
    int n_write;
    start_cnt = items_sent;
    while (items_sent - start_cnt < n_items) begin
      if ($urandom_range(99) < 75) begin
        repeat ($urandom_range(1, 3)) send_req(REQ_BEGIN, $urandom);
        n_write = $urandom_range(0, log_capacity() + 2);
        repeat (n_write) begin
          if ($urandom_range(99) < 10) send_req(REQ_BEGIN, $urandom);
          else send_req(REQ_WRITE, pick_block());
        end
        while (open_cnt != 0) send_req(REQ_END, $urandom);
      end else begin
        send_req(REQ_W'($urandom_range(3)), $urandom);
      end
    end
  endtask

  task automatic test_random_phases();
    tx_idle_pct = 12;
    rx_stall_pct = 79;
    write_regs($urandom, $urandom_range(20, 33), $urandom_range(1, 8));
    random_traffic(15);
    settle();
    tx_idle_pct = 79;
    rx_stall_pct = 12;
    write_regs(32'hFFFF_FFF0, $urandom_range(2, 12), $urandom_range(1, 4));
    random_traffic(15);
    settle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_regs('0, 33, $urandom_range(1, 32));
    random_traffic(15);
    settle();
  endtask

  initial begin
    log_start_q = LOG_START_RST;
    region_q = REGION_RST;
    reserve_q = RESERVE_RST;
    entry_cnt = 0;
    open_cnt = 0;
    tx_idle_pct = 12;
    rx_stall_pct = 79;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_misuse_cases();
    test_group_commit();
    test_full_log_wrap();
    test_admission_limits();
    test_backpressure_fill();
    test_random_phases();

    $display("Sent %0d requests and checked %0d result words under three pacing modes.",
             items_sent, words_checked);
    $display("Predicted %0d commit entries, %0d must-wait, %0d absorbed, %0d full-log errors.",
             commits_due, waits_due, absorbs_due, fulls_due);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
